// ===== sv/lre_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, constants and character decode for the letter RSA core.
package lre_pkg;

  localparam int IDX_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

  localparam logic [63:0] RESET_MODULUS  = 64'd28692529;
  localparam logic [63:0] RESET_EXPONENT = 64'd97;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_N    = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_UP_O    = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  localparam logic [IDX_W-1:0] IDX_ENYE = 5'd14;
  localparam logic [IDX_W-1:0] IDX_O    = 5'd15;

  typedef enum logic [1:0] {
    CK_SPACE,
    CK_BAD,
    CK_LETTER
  } char_kind_t;

  typedef struct packed {
    char_kind_t       kind;
    logic [IDX_W-1:0] idx;
  } char_info_t;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_BASE_GO,
    PS_BASE_WAIT,
    PS_SQR_GO,
    PS_SQR_WAIT,
    PS_MUL_GO,
    PS_MUL_WAIT,
    PS_NEXT,
    PS_FIN
  } pow_state_t;

  function automatic char_info_t lre_decode(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [CHAR_W-1:0] d;
    char_info_t        info;
    u = c;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      u = c - CASE_DELTA;
    end
    info.kind = CK_BAD;
    info.idx  = '0;
    if (c == CH_SPACE) begin
      info.kind = CK_SPACE;
    end else if (u >= CH_UP_A && u <= CH_UP_N) begin
      d         = u - CH_UP_A;
      info.kind = CK_LETTER;
      info.idx  = d[IDX_W-1:0];
    end else if (u == CH_HASH) begin
      info.kind = CK_LETTER;
      info.idx  = IDX_ENYE;
    end else if (u >= CH_UP_O && u <= CH_UP_Z) begin
      d         = u - CH_UP_O;
      info.kind = CK_LETTER;
      info.idx  = d[IDX_W-1:0] + IDX_O;
    end
    return info;
  endfunction

endpackage

// ===== sv/lre_chan_if.sv =====
`timescale 1ns / 1ps
// Interfaces: request channels for text bytes and cipher results.
interface lre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface lre_out_if #(
  parameter int MOD_BITS = 25
);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] cipher_value;
  logic                bad_char;

  modport source (output valid, output cipher_value, output bad_char, input ready);
  modport sink (input valid, input cipher_value, input bad_char, output ready);
endinterface

// ===== sv/lre_modmul.sv =====
`timescale 1ns / 1ps
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module lre_modmul #(
  parameter int MOD_BITS = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  input  logic [MOD_BITS-1:0] m,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);

  localparam int CNT_W = $clog2(MOD_BITS + 1);
  localparam int SUM_W = MOD_BITS + 2;

  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic [MOD_BITS-1:0] acc_r;
  logic [MOD_BITS-1:0] acc_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [SUM_W-1:0] sum;
  logic [SUM_W:0]   d1;
  logic [SUM_W:0]   d2;

  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (b_r[MOD_BITS-1] ? {2'b00, a_r} : {SUM_W{1'b0}});
    d1  = {1'b0, sum} - {3'b000, m};
    d2  = {1'b0, sum} - {2'b00, m, 1'b0};
    if (!d2[SUM_W]) begin
      acc_nxt = d2[MOD_BITS-1:0];
    end else if (!d1[SUM_W]) begin
      acc_nxt = d1[MOD_BITS-1:0];
    end else begin
      acc_nxt = sum[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MOD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[MOD_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== sv/lre_powseq.sv =====
`timescale 1ns / 1ps
// Square-and-multiply sequencer over the exponent bits, driving the serial multiplier.
module lre_powseq #(
  parameter int MOD_BITS = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lre_pkg::IDX_W-1:0]  idx,
  input  logic [MOD_BITS-1:0]        exp_val,
  input  logic [MOD_BITS-1:0]        m,
  output logic                       done,
  output logic [MOD_BITS-1:0]        result
);

  import lre_pkg::*;

  localparam int CNT_W = $clog2(MOD_BITS + 1);

  pow_state_t          state_r;
  pow_state_t          state_nxt;
  logic [MOD_BITS-1:0] e_r;
  logic [CNT_W-1:0]    ecnt_r;
  logic [MOD_BITS-1:0] base_r;
  logic [MOD_BITS-1:0] r_r;

  logic                mm_start;
  logic [MOD_BITS-1:0] mm_a;
  logic [MOD_BITS-1:0] mm_b;
  logic                mm_done;
  logic [MOD_BITS-1:0] mm_prod;

  lre_modmul #(
    .MOD_BITS (MOD_BITS)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .m     (m),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PS_IDLE: begin
        if (start) state_nxt = PS_BASE_GO;
      end
      PS_BASE_GO:   state_nxt = PS_BASE_WAIT;
      PS_BASE_WAIT: begin
        if (mm_done) state_nxt = PS_SQR_GO;
      end
      PS_SQR_GO:    state_nxt = PS_SQR_WAIT;
      PS_SQR_WAIT: begin
        if (mm_done) state_nxt = e_r[MOD_BITS-1] ? PS_MUL_GO : PS_NEXT;
      end
      PS_MUL_GO:    state_nxt = PS_MUL_WAIT;
      PS_MUL_WAIT: begin
        if (mm_done) state_nxt = PS_NEXT;
      end
      PS_NEXT:      state_nxt = (ecnt_r == CNT_W'(1)) ? PS_FIN : PS_SQR_GO;
      PS_FIN:       state_nxt = PS_IDLE;
      default:      state_nxt = PS_IDLE;
    endcase
  end

  always_comb begin
    mm_start = 1'b0;
    mm_a     = r_r;
    mm_b     = base_r;
    done     = 1'b0;
    unique case (state_r)
      PS_BASE_GO: begin
        mm_start = 1'b1;
        mm_a     = MOD_BITS'(1);
        mm_b     = base_r;
      end
      PS_SQR_GO: begin
        mm_start = 1'b1;
        mm_b     = r_r;
      end
      PS_MUL_GO: begin
        mm_start = 1'b1;
      end
      PS_FIN: begin
        done = 1'b1;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      PS_IDLE: begin
        if (start) begin
          e_r    <= exp_val;
          ecnt_r <= CNT_W'(MOD_BITS);
          base_r <= MOD_BITS'(idx);
        end
      end
      PS_BASE_WAIT: begin
        if (mm_done) begin
          base_r <= mm_prod;
          r_r    <= MOD_BITS'(1);
        end
      end
      PS_SQR_WAIT, PS_MUL_WAIT: begin
        if (mm_done) r_r <= mm_prod;
      end
      PS_NEXT: begin
        e_r    <= {e_r[MOD_BITS-2:0], 1'b0};
        ecnt_r <= ecnt_r - CNT_W'(1);
      end
      default: begin
        e_r <= e_r;
      end
    endcase
  end

  assign result = r_r;

endmodule

// ===== sv/letter_rsa_encrypt_core.sv =====
`timescale 1ns / 1ps
// Top level: letter decode, key registers, RSA exponentiation and result register.
// Path: a bad byte or a modulus below two is answered with zero through the result register, with no exponentiation;
//   a letter runs one base multiply, then a square per exponent bit and a multiply per set exponent bit,
//   each a bit-serial modular multiply, before its result is loaded into the result register.
// Throughput: one item at a time; a space is accepted while idle and gives no result.
// Reset: synchronous active-low rst_n loads modulus 28692529 and exponent 97, empties all.
module letter_rsa_encrypt_core #(
  parameter int MOD_BITS = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lre_in_if.sink                            in_ch,
  lre_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [lre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [MOD_BITS-1:0]               cfg_data
);

  import lre_pkg::*;

  logic [MOD_BITS-1:0] modulus_r;
  logic [MOD_BITS-1:0] exponent_r;

  logic                busy_r;
  logic                pend_rdy_r;
  logic                pend_bad_r;
  logic                pend_zero_r;
  logic                out_valid_r;
  logic [MOD_BITS-1:0] out_val_r;
  logic                out_bad_r;

  char_info_t          info;
  logic                in_acc;
  logic                pow_go;
  logic                pow_done;
  logic [MOD_BITS-1:0] pow_result;
  logic                out_load;

  assign info     = lre_decode(in_ch.char_code);
  assign in_ch.ready = !busy_r;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign pow_go   = in_acc && (info.kind == CK_LETTER) && (modulus_r >= MOD_BITS'(2));
  assign out_load = busy_r && pend_rdy_r && (!out_valid_r || out_ch.ready);

  lre_powseq #(
    .MOD_BITS (MOD_BITS)
  ) u_powseq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pow_go),
    .idx     (info.idx),
    .exp_val (exponent_r),
    .m       (modulus_r),
    .done    (pow_done),
    .result  (pow_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MOD_BITS'(RESET_MODULUS);
      exponent_r <= MOD_BITS'(RESET_EXPONENT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:  modulus_r  <= cfg_data;
        CFG_EXPONENT: exponent_r <= cfg_data;
        default:      modulus_r  <= modulus_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_rdy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && info.kind != CK_SPACE) begin
        busy_r     <= 1'b1;
        pend_rdy_r <= !pow_go;
      end
      if (pow_done) begin
        pend_rdy_r <= 1'b1;
      end
      if (out_load) begin
        busy_r      <= 1'b0;
        pend_rdy_r  <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && info.kind != CK_SPACE) begin
      pend_bad_r  <= (info.kind == CK_BAD);
      pend_zero_r <= !pow_go;
    end
    if (out_load) begin
      out_val_r <= pend_zero_r ? '0 : pow_result;
      out_bad_r <= pend_bad_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cipher_value = out_val_r;
  assign out_ch.bad_char     = out_bad_r;

`ifndef ASSERT_OFF
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_val_r == '0)
    else $error("bad character result carries a nonzero value");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    pow_done |-> busy_r && !pend_rdy_r)
    else $error("exponentiation finished with no request waiting");

  a_pend_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_rdy_r |-> busy_r)
    else $error("pending result outside a busy period");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && info.kind != CK_SPACE |=> busy_r)
    else $error("non-space request did not mark the core busy");
`endif

endmodule
